// ===== sv/rti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// shared widths, result codes and pipeline side-band types for the
// axis-parallel ray / triangle intersection pipeline
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int FRAC_BITS  = 16;                 // q16.16 coordinates
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;        // vertex differences
  localparam int PROD_W     = 2 * DIFF_W;         // 2x2 products
  localparam int DET_W      = PROD_W + 1;         // det, ns, nt
  localparam int SUM_W      = DET_W + 1;          // ns + nt
  localparam int SPLIT_W    = 34;                 // low slice of det/ns/nt
  localparam int HI_W       = DET_W - SPLIT_W;    // signed high slice
  localparam int PLO_W      = SPLIT_W + 1 + DIFF_W;
  localparam int PHI_W      = HI_W + DIFF_W;
  localparam int PFULL_W    = DET_W + DIFF_W + 1;
  localparam int NUM_W      = PFULL_W + 2;        // sum of three products
  localparam int QUO_W      = 32;                 // quotient bits resolved
  localparam int IN_DATA_W  = 11 * COORD_W;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    REASON_HIT       = 2'd0,
    REASON_SLAB      = 2'd1,
    REASON_SINGULAR  = 2'd2,
    REASON_OUTSIDE   = 2'd3
  } reason_t;

  typedef struct packed {
    reason_t reason;
    logic    qneg;
  } rti_side_t;

endpackage

// ===== sv/rti_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_div
// pipelined restoring divider, one quotient bit per stage, msb first
// ----------------------------------------------------------------------------
module rti_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rti_pkg::NUM_W-1:0]     in_num,
  input  logic [rti_pkg::DET_W-1:0]     in_den,
  input  rti_pkg::rti_side_t            in_side,
  output logic                          out_valid,
  output logic [rti_pkg::QUO_W-1:0]     out_quo,
  output rti_pkg::rti_side_t            out_side
);

  localparam int NS = rti_pkg::QUO_W;

  logic                         v    [0:NS];
  logic [rti_pkg::NUM_W-1:0]    rem  [0:NS];
  logic [rti_pkg::DET_W-1:0]    den  [0:NS];
  logic [rti_pkg::QUO_W-1:0]    quo  [0:NS];
  rti_pkg::rti_side_t           side [0:NS];

  assign v[0]    = in_valid;
  assign rem[0]  = in_num;
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int B = NS - k;   // quotient bit resolved here
    logic [rti_pkg::NUM_W-1:0] dsh;
    logic                      ge;
    assign dsh = {{(rti_pkg::NUM_W - rti_pkg::DET_W){1'b0}}, den[k-1]} << B;
    assign ge  = rem[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? rem[k-1] - dsh : rem[k-1];
        quo[k]  <= quo[k-1] | ({{(rti_pkg::QUO_W-1){1'b0}}, ge} << B);
        den[k]  <= den[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = v[NS];
  assign out_quo   = quo[NS];
  assign out_side  = side[NS];

endmodule

// ===== sv/axis_ray_triangle_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_ray_triangle_intersect_top
// axis-parallel ray versus triangle test: slab check, cramer solve, exact
// barycentric test and interpolated hit position along the ray axis
// ----------------------------------------------------------------------------
// channel   direction  width  contents
// s_axis    in         352    triangle a,b,c and ray coordinates
// m_axis    out        40     hit, reason, position
// cfg       in         1      ray_axis register write
//
// one item per cycle sustained while m_axis accepts; an item passes 7 math stages,
// then the 32-stage quotient pipeline, then the output register
// rst clears every valid bit and ray_axis; payload registers are not reset
// the whole pipeline advances together, a stall at m_axis holds every stage
// ----------------------------------------------------------------------------
module axis_ray_triangle_intersect_top (
  input  logic                              clk,
  input  logic                              rst,
  // a_x a_y a_z b_x b_y b_z c_x c_y c_z ray_first ray_second, 32 bits each
  input  logic [rti_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // hit [0], reason [2:1], position [34:3], zero fill [39:35]
  output logic [rti_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);

  localparam int CW = rti_pkg::COORD_W;
  localparam int DW = rti_pkg::DIFF_W;

  logic ray_axis;
  logic en;

  // global advance: output register free or being drained
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_axis <= 1'b0;
    end else if (cfg_wr_en) begin
      ray_axis <= cfg_wr_data;
    end
  end

  // unpack input item
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, r1, r2;
  assign ax = s_axis_tdata[0*CW +: CW];
  assign ay = s_axis_tdata[1*CW +: CW];
  assign az = s_axis_tdata[2*CW +: CW];
  assign bx = s_axis_tdata[3*CW +: CW];
  assign by = s_axis_tdata[4*CW +: CW];
  assign bz = s_axis_tdata[5*CW +: CW];
  assign cx = s_axis_tdata[6*CW +: CW];
  assign cy = s_axis_tdata[7*CW +: CW];
  assign cz = s_axis_tdata[8*CW +: CW];
  assign r1 = s_axis_tdata[9*CW +: CW];
  assign r2 = s_axis_tdata[10*CW +: CW];

  // known coordinate (u) and coordinate along the ray (p)
  logic signed [CW-1:0] au, bu, cu, ap, bp, cp;
  assign au = ray_axis ? ax : ay;
  assign bu = ray_axis ? bx : by;
  assign cu = ray_axis ? cx : cy;
  assign ap = ray_axis ? ay : ax;
  assign bp = ray_axis ? by : bx;
  assign cp = ray_axis ? cy : cx;

  logic slab_in;
  assign slab_in = (r1 < au && r1 < bu && r1 < cu) || (r1 > au && r1 > bu && r1 > cu) ||
                   (r2 < az && r2 < bz && r2 < cz) || (r2 > az && r2 > bz && r2 > cz);

  // stage 1: differences
  logic                 v1, slab1;
  logic signed [DW-1:0] a11, a12, a21, a22, b1, b2, dx1, dy1, vap1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slab1 <= slab_in;
      a11   <= DW'(bu) - DW'(au);
      a12   <= DW'(cu) - DW'(au);
      a21   <= DW'(bz) - DW'(az);
      a22   <= DW'(cz) - DW'(az);
      b1    <= DW'(r1) - DW'(au);
      b2    <= DW'(r2) - DW'(az);
      dx1   <= DW'(bp) - DW'(ap);
      dy1   <= DW'(cp) - DW'(ap);
      vap1  <= DW'(ap);
    end
  end

  // stage 2: six 33x33 products
  logic                             v2, slab2;
  logic signed [rti_pkg::PROD_W-1:0] m1, m2, m3, m4, m5, m6;
  logic signed [DW-1:0]             dx2, dy2, vap2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slab2 <= slab1;
      m1    <= a11 * a22;
      m2    <= a12 * a21;
      m3    <= b1 * a22;
      m4    <= a12 * b2;
      m5    <= a11 * b2;
      m6    <= b1 * a21;
      dx2   <= dx1;
      dy2   <= dy1;
      vap2  <= vap1;
    end
  end

  // stage 3: determinant and cramer numerators
  logic                             v3, slab3;
  logic signed [rti_pkg::DET_W-1:0] det3, ns3, nt3;
  logic signed [DW-1:0]             dx3, dy3, vap3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slab3 <= slab2;
      det3  <= rti_pkg::DET_W'(m1) - rti_pkg::DET_W'(m2);
      ns3   <= rti_pkg::DET_W'(m3) - rti_pkg::DET_W'(m4);
      nt3   <= rti_pkg::DET_W'(m5) - rti_pkg::DET_W'(m6);
      dx3   <= dx2;
      dy3   <= dy2;
      vap3  <= vap2;
    end
  end

  // stage 4: inside test, reason code, split partial products
  logic signed [rti_pkg::SUM_W-1:0] sum3;
  logic                             ok3;
  rti_pkg::reason_t                 reason_c;

  assign sum3 = rti_pkg::SUM_W'(ns3) + rti_pkg::SUM_W'(nt3);

  always_comb begin
    if (!det3[rti_pkg::DET_W-1]) begin
      ok3 = !ns3[rti_pkg::DET_W-1] && !nt3[rti_pkg::DET_W-1] &&
            (sum3 <= rti_pkg::SUM_W'(det3));
    end else begin
      ok3 = (ns3 <= 0) && (nt3 <= 0) && (sum3 >= rti_pkg::SUM_W'(det3));
    end
    priority if (slab3) begin
      reason_c = rti_pkg::REASON_SLAB;
    end else if (det3 == '0) begin
      reason_c = rti_pkg::REASON_SINGULAR;
    end else if (ok3) begin
      reason_c = rti_pkg::REASON_HIT;
    end else begin
      reason_c = rti_pkg::REASON_OUTSIDE;
    end
  end

  localparam int SW = rti_pkg::SPLIT_W;

  logic                             v4;
  rti_pkg::reason_t                 reason4;
  logic signed [rti_pkg::DET_W-1:0] det4;
  logic signed [rti_pkg::PLO_W-1:0] plo_d, plo_s, plo_t;
  logic signed [rti_pkg::PHI_W-1:0] phi_d, phi_s, phi_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reason4 <= reason_c;
      det4    <= det3;
      plo_d   <= $signed({1'b0, det3[SW-1:0]}) * vap3;
      plo_s   <= $signed({1'b0, ns3[SW-1:0]}) * dx3;
      plo_t   <= $signed({1'b0, nt3[SW-1:0]}) * dy3;
      phi_d   <= $signed(det3[rti_pkg::DET_W-1:SW]) * vap3;
      phi_s   <= $signed(ns3[rti_pkg::DET_W-1:SW]) * dx3;
      phi_t   <= $signed(nt3[rti_pkg::DET_W-1:SW]) * dy3;
    end
  end

  // stage 5: recombine partial products
  localparam int PW = rti_pkg::PFULL_W;

  logic                             v5;
  rti_pkg::reason_t                 reason5;
  logic signed [rti_pkg::DET_W-1:0] det5;
  logic signed [PW-1:0]             p_d, p_s, p_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reason5 <= reason4;
      det5    <= det4;
      p_d     <= (PW'(phi_d) <<< SW) + PW'(plo_d);
      p_s     <= (PW'(phi_s) <<< SW) + PW'(plo_s);
      p_t     <= (PW'(phi_t) <<< SW) + PW'(plo_t);
    end
  end

  // stage 6: interpolation numerator
  logic                             v6;
  rti_pkg::reason_t                 reason6;
  logic signed [rti_pkg::DET_W-1:0] det6;
  logic signed [rti_pkg::NUM_W-1:0] num6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reason6 <= reason5;
      det6    <= det5;
      num6    <= rti_pkg::NUM_W'(p_d) + rti_pkg::NUM_W'(p_s) + rti_pkg::NUM_W'(p_t);
    end
  end

  // stage 7: sign and magnitude for the divider
  logic                         v7;
  rti_pkg::rti_side_t           side7;
  logic [rti_pkg::NUM_W-1:0]    nmag7;
  logic [rti_pkg::DET_W-1:0]    dmag7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side7.reason <= reason6;
      side7.qneg   <= num6[rti_pkg::NUM_W-1] ^ det6[rti_pkg::DET_W-1];
      nmag7        <= num6[rti_pkg::NUM_W-1] ? -num6 : num6;
      dmag7        <= det6[rti_pkg::DET_W-1] ? -det6 : det6;
    end
  end

  // quotient pipeline, truncates toward zero on magnitudes
  logic                      vq;
  logic [rti_pkg::QUO_W-1:0] quo;
  rti_pkg::rti_side_t        sideq;

  rti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_num    (nmag7),
    .in_den    (dmag7),
    .in_side   (side7),
    .out_valid (vq),
    .out_quo   (quo),
    .out_side  (sideq)
  );

  // output register: sign, saturate, zero position when no hit
  logic signed [rti_pkg::QUO_W+1:0] qs;
  logic signed [CW-1:0]             pos_c;
  logic                             hit_c;

  assign qs    = sideq.qneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign hit_c = (sideq.reason == rti_pkg::REASON_HIT);

  always_comb begin
    if (!hit_c) begin
      pos_c = '0;
    end else if (qs > $signed({3'b000, {(CW-1){1'b1}}})) begin
      pos_c = {1'b0, {(CW-1){1'b1}}};
    end else if (qs < -$signed({2'b00, 1'b1, {(CW-1){1'b0}}})) begin
      pos_c = {1'b1, {(CW-1){1'b0}}};
    end else begin
      pos_c = qs[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {5'b00000, pos_c, sideq.reason, hit_c};
    end
  end

endmodule

// ===== dv/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// watches the triangle and result channels, predicts every result from the
// accepted triangle item and the current ray axis, and compares in order
// ----------------------------------------------------------------------------
module rti_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rti_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [rti_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  output int                                errors,
  output int                                pending
);

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic [31:0]      position;
    rti_pkg::reason_t reason;
    logic             hit;
  } hit_result_t;

  logic          axis_sel;
  hit_result_t   expected_hits[$];

  function automatic bit beyond_all(longint r, longint p, longint q, longint s);
    return (r < p && r < q && r < s) || (r > p && r > q && r > s);
  endfunction

  // exact intersection result for one triangle item
  function automatic hit_result_t predict_result(logic [rti_pkg::IN_DATA_W-1:0] d,
                                                 logic ax);
    longint      va[3], vb[3], vc[3];
    longint      r1, r2;
    int          ku, kp;
    wide_t       a11, a12, a21, a22, b1, b2, det, ns, nt, sum, num, q;
    bit          ok;
    hit_result_t res;
    for (int k = 0; k < 3; k++) begin
      va[k] = longint'($signed(d[32*k +: 32]));
      vb[k] = longint'($signed(d[32*(3+k) +: 32]));
      vc[k] = longint'($signed(d[32*(6+k) +: 32]));
    end
    r1 = longint'($signed(d[32*9 +: 32]));
    r2 = longint'($signed(d[32*10 +: 32]));
    ku = ax ? 0 : 1;
    kp = ax ? 1 : 0;
    res = '0;
    if (beyond_all(r1, va[ku], vb[ku], vc[ku]) || beyond_all(r2, va[2], vb[2], vc[2])) begin
      res.reason = rti_pkg::REASON_SLAB;
      return res;
    end
    a11 = wide_t'(vb[ku] - va[ku]);
    a12 = wide_t'(vc[ku] - va[ku]);
    a21 = wide_t'(vb[2] - va[2]);
    a22 = wide_t'(vc[2] - va[2]);
    b1  = wide_t'(r1 - va[ku]);
    b2  = wide_t'(r2 - va[2]);
    det = a11 * a22 - a12 * a21;
    if (det == 0) begin
      res.reason = rti_pkg::REASON_SINGULAR;
      return res;
    end
    ns  = b1 * a22 - a12 * b2;
    nt  = a11 * b2 - b1 * a21;
    sum = ns + nt;
    if (det > 0) ok = (ns >= 0) && (nt >= 0) && (sum <= det);
    else         ok = (ns <= 0) && (nt <= 0) && (sum >= det);
    if (!ok) begin
      res.reason = rti_pkg::REASON_OUTSIDE;
      return res;
    end
    num = wide_t'(va[kp]) * det + ns * wide_t'(vb[kp] - va[kp])
        + nt * wide_t'(vc[kp] - va[kp]);
    q = num / det;  // truncates toward zero
    if (q > wide_t'(64'sd2147483647)) q = wide_t'(64'sd2147483647);
    else if (q < wide_t'(-64'sd2147483648)) q = wide_t'(-64'sd2147483648);
    res.hit      = 1'b1;
    res.reason   = rti_pkg::REASON_HIT;
    res.position = q[31:0];
    return res;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    hit_result_t want, got;
    if (rst) begin
      axis_sel = 1'b0;
    end else begin
      if (cfg_wr_en) axis_sel = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        expected_hits.insert(expected_hits.size(), predict_result(s_axis_tdata, axis_sel));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[34:0];
        if (expected_hits.size() == 0) begin
          report("unexpected result, hit", -1, got.hit);
        end else begin
          want = expected_hits.pop_front();
          if (want.hit != got.hit) report("hit", want.hit, got.hit);
          if (want.reason != got.reason) report("reason", want.reason, got.reason);
          if (want.position != got.position)
            report("position", $signed(want.position), $signed(got.position));
        end
      end
    end
    pending = expected_hits.size();
  end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// ray / triangle intersection test: directed corner triangles, then random
// triangles for both ray axes under random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ONE = 1 << rti_pkg::FRAC_BITS;   // 1.0 in q16.16

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic [rti_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rti_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic                             cfg_wr_data = 1'b0;
  int                               errors, pending;
  int                               cycles = 0;
  bit                               no_idle = 1'b0;   // stretches with back-to-back items
  int                               ready_hold = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  axis_ray_triangle_intersect_top u_dut (
    .clk, .rst,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_wr_en, .cfg_wr_data
  );

  rti_checker u_checker (
    .clk, .rst,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_wr_en, .cfg_wr_data,
    .errors, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // result side: random stall of tready after each accepted result, none when no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ready_hold = draw_gap();
      if (ready_hold > 0) begin
        ready_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // present one triangle item, holding tvalid high across back-to-back items
  task automatic send_item(int f[11]);
    int gap;
    logic [rti_pkg::IN_DATA_W-1:0] d;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int k = 0; k < 11; k++) d[32*k +: 32] = f[k];
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drain, let the pipeline settle, then write the ray axis
  task automatic set_ray_axis(logic ax);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ax;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random triangle: mostly well-formed with the ray inside the bounding box
  task automatic random_item();
    int f[11];
    int pick, span, lo, hi;
    pick = $urandom_range(0, 99);
    for (int k = 0; k < 11; k++) f[k] = $urandom;
    if (pick < 70) begin
      span = (pick < 10) ? 32'h7fff_ffff : (1 << $urandom_range(2, 28));
      for (int k = 0; k < 9; k++) f[k] = $signed($urandom_range(0, span)) - span / 2;
      if (pick >= 60) begin
        // collinear in every coordinate: singular projection
        f[6] = f[3]; f[7] = f[4]; f[8] = f[5];
      end
      for (int j = 0; j < 2; j++) begin
        // j=0 picks x or y at random; the first known coord varies by axis
        int c;
        c = (j == 0) ? $urandom_range(0, 1) : 2;
        lo = f[c]; hi = f[c];
        for (int v = 1; v < 3; v++) begin
          if (f[3*v+c] < lo) lo = f[3*v+c];
          if (f[3*v+c] > hi) hi = f[3*v+c];
        end
        f[9+j] = lo + int'($urandom_range(0, hi - lo));
      end
    end
    send_item(f);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ray axis x after reset
    send_item('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff});
    send_item('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000});
    // extreme corner triangle spanning the full range, ray at the origin
    send_item('{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0});
    // unit triangle in y-z at x = 3, interior hit
    send_item('{3*ONE, 0, 0, 3*ONE, ONE, 0, 3*ONE, 0, ONE, ONE/4, ONE/4});
    // slanted triangle, interior and vertex and edge hits
    send_item('{0, 0, 0, 5*ONE, ONE, 0, -7*ONE, 0, ONE, ONE/3, ONE/5});
    send_item('{0, 0, 0, 5*ONE, ONE, 0, -7*ONE, 0, ONE, ONE, 0});
    send_item('{0, 0, 0, 5*ONE, ONE, 0, -7*ONE, 0, ONE, ONE/2, ONE/2});
    // swapped vertices: negative determinant
    send_item('{0, 0, 0, -7*ONE, 0, ONE, 5*ONE, ONE, 0, ONE/3, ONE/5});
    // outside triangle but inside the slab
    send_item('{0, 0, 0, 5*ONE, ONE, 0, -7*ONE, 0, ONE, 3*ONE/4, 3*ONE/4});
    // slab: first coordinate below, above; z below, above
    send_item('{0, 0, 0, 0, ONE, 0, 0, 0, ONE, -1, 0});
    send_item('{0, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE + 1, 0});
    send_item('{0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, -1});
    send_item('{0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE + 1});
    // degenerate triangle: all vertices equal, ray on it
    send_item('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
    // edge-on projection: triangle in the x-y plane
    send_item('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, 0});
    // tiny fractional triangle with a negative position
    send_item('{-3, 0, 0, -5, 3, 0, -1, 0, 3, 1, 1});

    // ray axis y: hit on a triangle projected onto x-z, slab cases below in x and above in z
    set_ray_axis(1'b1);
    send_item('{0, 2*ONE, 0, ONE, 2*ONE, 0, 0, -2*ONE, ONE, ONE/4, ONE/4});
    send_item('{0, 0, 0, ONE, ONE, 0, 0, 0, ONE, -1, 0});
    send_item('{0, 0, 0, ONE, ONE, 0, 0, 0, ONE, 0, ONE + 1});
    send_item('{-3, 7, 0, 5, -9, 0, -1, 2, 3, 1, 1});

    // random phases alternating the axis, with the idling style redrawn every 40 items
    for (int ph = 0; ph < 6; ph++) begin
      set_ray_axis(ph[0]);
      for (int n = 0; n < 175; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_item();
      end
      no_idle = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/rti_pkg.sv
sv/rti_div.sv
sv/axis_ray_triangle_intersect_top.sv
dv/rti_checker.sv
dv/tb_top.sv
